// File: design/oneshot_periodic_timer_bank_defines.svh
// Assertion macros shared by the timer bank RTL.
// Depends on nothing; included by the top level.
`ifndef ONESHOT_PERIODIC_TIMER_BANK_DEFINES_SVH
`define ONESHOT_PERIODIC_TIMER_BANK_DEFINES_SVH

// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define OPTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Antecedent holds in a cycle, so the consequent holds in the next cycle.
`define OPTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

// File: design/optb_pkg.sv
// Types and constants of the one-shot / periodic timer bank.
// Depends on nothing; used by optb_cell and the top level.
package optb_pkg;

    localparam int HANDLE_W = 5;
    localparam int DUR_W    = 32;
    localparam int MASK_W   = 16;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_ADD_ONE = 3'd1;
    localparam logic [2:0] REQ_ADD_PER = 3'd2;
    localparam logic [2:0] REQ_DEL_ONE = 3'd3;
    localparam logic [2:0] REQ_DEL_PER = 3'd4;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [DUR_W-1:0]    duration;
        logic [HANDLE_W-1:0] slot_handle;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                ok;
        logic [MASK_W-1:0]   oneshot_fired;
        logic [MASK_W-1:0]   periodic_fired;
    } t_result;

    // Per-bank command broadcast to every cell of that bank.
    typedef struct packed {
        logic                tick;
        logic                add;
        logic                del;
        logic [HANDLE_W-1:0] del_handle;
    } t_cell_ctl;

    // Data handed from one cell to the next along the chain.
    typedef struct packed {
        logic                claimed;
        logic [HANDLE_W-1:0] handle;
        logic                del_hit;
    } t_link;

endpackage

// File: design/optb_cell.sv
// One timer slot: active flag, down counter and, for periodic slots, the period.
// Depends on optb_pkg.
module optb_cell #(
    parameter int COUNT_BITS  = 32,
    parameter int IDX         = 0,
    parameter bit IS_PERIODIC = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  optb_pkg::t_cell_ctl   i_ctl,
    input  logic [COUNT_BITS-1:0] i_load,
    input  optb_pkg::t_link       i_link,
    output optb_pkg::t_link       o_link,
    output logic                  o_fire
);
    import optb_pkg::*;

    localparam logic [HANDLE_W-1:0] MY_HANDLE = HANDLE_W'(IDX + 1);

    logic                  r_active;
    logic [COUNT_BITS-1:0] r_remaining;
    logic [COUNT_BITS-1:0] r_reload;
    logic                  take;
    logic                  del_me;

    // The lowest free cell whose lower neighbors are all busy takes the add.
    assign take   = i_ctl.add && !i_link.claimed && !r_active;
    assign del_me = i_ctl.del && r_active && (i_ctl.del_handle == MY_HANDLE);
    assign o_fire = i_ctl.tick && r_active && (r_remaining == COUNT_BITS'(1));

    always_comb begin
        o_link.claimed = i_link.claimed || !r_active;
        o_link.handle  = (!i_link.claimed && !r_active) ? MY_HANDLE : i_link.handle;
        o_link.del_hit = i_link.del_hit || del_me;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (take) begin
            r_active <= 1'b1;
        end else if (del_me) begin
            r_active <= 1'b0;
        end else if (o_fire && !IS_PERIODIC) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_remaining <= i_load;
        end else if (del_me) begin
            r_remaining <= '0;
        end else if (o_fire) begin
            r_remaining <= IS_PERIODIC ? r_reload : '0;
        end else if (i_ctl.tick && r_active) begin
            r_remaining <= r_remaining - COUNT_BITS'(1);
        end
    end

    generate
        if (IS_PERIODIC) begin : g_period
            always_ff @(posedge i_clk) begin
                if (take) begin
                    r_reload <= i_load;
                end
            end
        end else begin : g_no_period
            assign r_reload = '0;
        end
    endgenerate

endmodule

// File: design/oneshot_periodic_timer_bank.sv
// Top level of the one-shot / periodic software timer bank.
// Depends on optb_pkg, optb_cell and oneshot_periodic_timer_bank_defines.svh.
//
//   Channel   Signals                  Direction  Handshake
//   request   start, busy, i_req       in         taken when start=1 and busy=0
//   result    o_valid, o_result        out        one-cycle strobe, never stalled
//
// Every request is taken, and its result shows on o_result, with
// o_valid high, for exactly the cycle after it was taken. busy stays low, so a
// request may come in every cycle. The cycle is set by the slot cells: each does
// one counter decrement and compare, and the add search ripples through the chain.
// Reset (synchronous, active low) frees every slot and drops o_valid.
// The receiver cannot stall the block; a result not sampled is gone.
module oneshot_periodic_timer_bank #(
    parameter int ONESHOT_SLOTS  = 16,
    parameter int PERIODIC_SLOTS = 16,
    parameter int COUNT_BITS     = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  optb_pkg::t_req    i_req,
    output logic              o_valid,
    output optb_pkg::t_result o_result
);
    import optb_pkg::*;

`include "oneshot_periodic_timer_bank_defines.svh"

    logic                  accept;
    logic                  dur_nonzero;
    logic [DUR_W-1:0]      dur_high;
    logic [COUNT_BITS-1:0] load_value;

    t_cell_ctl one_ctl;
    t_cell_ctl per_ctl;

    // Chains of links: entry 0 feeds cell 0, entry N is the end of the bank.
    t_link one_link [ONESHOT_SLOTS+1];
    t_link per_link [PERIODIC_SLOTS+1];

    logic [ONESHOT_SLOTS-1:0]  one_fire;
    logic [PERIODIC_SLOTS-1:0] per_fire;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    // The bank takes every request as it comes, so it is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Durations beyond the counter width saturate to the largest count.
    assign dur_nonzero = |i_req.duration;
    assign dur_high    = i_req.duration >> COUNT_BITS;
    assign load_value  = (|dur_high) ? '1 : i_req.duration[COUNT_BITS-1:0];

    // Decode the request into a command for each bank.
    always_comb begin
        one_ctl            = '0;
        per_ctl            = '0;
        one_ctl.del_handle = i_req.slot_handle;
        per_ctl.del_handle = i_req.slot_handle;
        if (accept) begin
            unique case (i_req.req_type)
                REQ_TICK: begin
                    one_ctl.tick = 1'b1;
                    per_ctl.tick = 1'b1;
                end
                REQ_ADD_ONE: begin
                    one_ctl.add = dur_nonzero;
                end
                REQ_ADD_PER: begin
                    per_ctl.add = dur_nonzero;
                end
                REQ_DEL_ONE: begin
                    one_ctl.del = 1'b1;
                end
                REQ_DEL_PER: begin
                    per_ctl.del = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign one_link[0] = '0;
    assign per_link[0] = '0;

    generate
        for (genvar g = 0; g < ONESHOT_SLOTS; g++) begin : g_one
            optb_cell #(
                .COUNT_BITS  (COUNT_BITS),
                .IDX         (g),
                .IS_PERIODIC (1'b0)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (one_ctl),
                .i_load  (load_value),
                .i_link  (one_link[g]),
                .o_link  (one_link[g+1]),
                .o_fire  (one_fire[g])
            );
        end
        for (genvar g = 0; g < PERIODIC_SLOTS; g++) begin : g_per
            optb_cell #(
                .COUNT_BITS  (COUNT_BITS),
                .IDX         (g),
                .IS_PERIODIC (1'b1)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (per_ctl),
                .i_load  (load_value),
                .i_link  (per_link[g]),
                .o_link  (per_link[g+1]),
                .o_fire  (per_fire[g])
            );
        end
    endgenerate

    // Assemble the answer from the ends of the two chains. The claimed flag at
    // the end of a chain says some cell was free, and the handle names the
    // lowest one. Fire bits are only nonzero on a tick.
    always_comb begin
        n_result                = '0;
        n_result.oneshot_fired  = MASK_W'(one_fire);
        n_result.periodic_fired = MASK_W'(per_fire);
        unique case (i_req.req_type)
            REQ_TICK: begin
                n_result.ok = 1'b1;
            end
            REQ_ADD_ONE: begin
                if (dur_nonzero && one_link[ONESHOT_SLOTS].claimed) begin
                    n_result.ok     = 1'b1;
                    n_result.handle = one_link[ONESHOT_SLOTS].handle;
                end
            end
            REQ_ADD_PER: begin
                if (dur_nonzero && per_link[PERIODIC_SLOTS].claimed) begin
                    n_result.ok     = 1'b1;
                    n_result.handle = per_link[PERIODIC_SLOTS].handle;
                end
            end
            REQ_DEL_ONE: begin
                n_result.ok = one_link[ONESHOT_SLOTS].del_hit;
            end
            REQ_DEL_PER: begin
                n_result.ok = per_link[PERIODIC_SLOTS].del_hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Each taken request gives exactly one result in the next cycle.
    `OPTB_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_valid)
    `OPTB_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, !accept, !o_valid)
    // A granted handle always comes with success.
    `OPTB_ASSERT_SAME(a_handle_means_ok, i_clk, i_rst_n,
        o_valid && (o_result.handle != '0), o_result.ok)
    // Expiry reports belong to ticks only, which carry no handle.
    `OPTB_ASSERT_SAME(a_fire_only_on_tick, i_clk, i_rst_n,
        o_valid && ((o_result.oneshot_fired != '0) || (o_result.periodic_fired != '0)),
        o_result.ok && (o_result.handle == '0))

endmodule
